// File: design/hjd_pkg.sv
// ----------------------------------------------------------------------------
// hjd_pkg
// Shared types and constants for the headset jack detector: item structs,
// configuration register map, jack kind and button event codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hjd_pkg;

  localparam int unsigned TimerWidthDef = 16;
  localparam int unsigned CfgTimeW      = 16;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 16;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PLUG_DEBOUNCE   = 3'd0,
    CFG_BUTTON_DEBOUNCE = 3'd1,
    CFG_MIC_SETTLE      = 3'd2,
    CFG_PLUGGED_LEVEL   = 3'd3,
    CFG_PRESSED_LEVEL   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_MIC    = 2'd1,
    KIND_NO_MIC = 2'd2
  } jack_kind_e;

  typedef enum logic [1:0] {
    BTN_NONE    = 2'd0,
    BTN_PRESS   = 2'd1,
    BTN_RELEASE = 2'd2
  } btn_event_e;

  // reset values of the configuration registers
  localparam logic [CfgTimeW-1:0] PlugDebounceRst  = 16'd500;
  localparam logic [CfgTimeW-1:0] ButtonDebounceRst = 16'd80;
  localparam logic [CfgTimeW-1:0] MicSettleRst     = 16'd100;
  localparam logic                PluggedLevelRst  = 1'b1;
  localparam logic                PressedLevelRst  = 1'b0;

  // pin history after reset: not plugged, released
  localparam logic PrevDetectRst = ~PluggedLevelRst;
  localparam logic PrevHookRst   = ~PressedLevelRst;

  typedef struct packed {
    logic detect_pin;
    logic hook_pin;
  } in_item_t;

  typedef struct packed {
    logic [1:0] jack_kind;
    logic       bias_enable;
    logic       jack_changed;
    logic [1:0] button_event;
    logic       button_down;
  } out_item_t;

  typedef struct packed {
    logic [CfgTimeW-1:0] plug_debounce_ticks;
    logic [CfgTimeW-1:0] button_debounce_ticks;
    logic [CfgTimeW-1:0] mic_settle_ticks;
    logic                plugged_level;
    logic                pressed_level;
  } cfg_t;

  // next jack status handed from the plug logic to the button logic
  typedef struct packed {
    jack_kind_e kind;
    logic       bias;
    logic       changed;
    logic       mic_found;
  } jack_info_t;

  typedef struct packed {
    btn_event_e evt;
    logic       down;
  } btn_info_t;

endpackage

`default_nettype wire

// File: design/hjd_cfg_regs.sv
// ----------------------------------------------------------------------------
// hjd_cfg_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module hjd_cfg_regs import hjd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                cfg_ready_o,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PLUG_DEBOUNCE:   cfg_d.plug_debounce_ticks   = cfg_data_i[CfgTimeW-1:0];
        CFG_BUTTON_DEBOUNCE: cfg_d.button_debounce_ticks = cfg_data_i[CfgTimeW-1:0];
        CFG_MIC_SETTLE:      cfg_d.mic_settle_ticks      = cfg_data_i[CfgTimeW-1:0];
        CFG_PLUGGED_LEVEL:   cfg_d.plugged_level         = cfg_data_i[0];
        CFG_PRESSED_LEVEL:   cfg_d.pressed_level         = cfg_data_i[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.plug_debounce_ticks   <= PlugDebounceRst;
      cfg_q.button_debounce_ticks <= ButtonDebounceRst;
      cfg_q.mic_settle_ticks      <= MicSettleRst;
      cfg_q.plugged_level         <= PluggedLevelRst;
      cfg_q.pressed_level         <= PressedLevelRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: design/hjd_jack_ctrl.sv
// ----------------------------------------------------------------------------
// hjd_jack_ctrl
// Plug debounce, mic bias control and microphone settle test.
// ----------------------------------------------------------------------------
`default_nettype none

module hjd_jack_ctrl import hjd_pkg::*; #(
  parameter int unsigned TimerWidth = TimerWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  in_item_t   item_i,
  input  cfg_t       cfg_i,
  output jack_info_t info_o
);

  localparam int unsigned LoadW = (TimerWidth > CfgTimeW) ? TimerWidth : CfgTimeW;
  localparam logic [LoadW-1:0] TimerMax = LoadW'({TimerWidth{1'b1}});

  jack_kind_e            jack_q, jack_d;
  logic [TimerWidth-1:0] plug_cnt_q, plug_cnt_d;
  logic [TimerWidth-1:0] settle_cnt_q, settle_cnt_d;
  logic                  plug_armed_q, plug_armed_d;
  logic                  settling_q, settling_d;
  logic                  prev_detect_q;
  logic                  bias_q, bias_d;

  logic [LoadW-1:0]      plug_ext, settle_ext;
  logic [TimerWidth-1:0] plug_load, settle_load;
  logic                  none, plugged, start, fin;

  // load values saturate at the counter range, debounce of zero acts as one
  always_comb begin
    plug_ext = LoadW'(cfg_i.plug_debounce_ticks);
    if (plug_ext == '0) begin
      plug_ext = LoadW'(1);
    end
    if (plug_ext > TimerMax) begin
      plug_ext = TimerMax;
    end
    settle_ext = LoadW'(cfg_i.mic_settle_ticks);
    if (settle_ext > TimerMax) begin
      settle_ext = TimerMax;
    end
    plug_load   = plug_ext[TimerWidth-1:0];
    settle_load = settle_ext[TimerWidth-1:0];
  end

  always_comb begin
    jack_d       = jack_q;
    plug_cnt_d   = plug_cnt_q;
    plug_armed_d = plug_armed_q;
    settle_cnt_d = settle_cnt_q;
    settling_d   = settling_q;
    bias_d       = bias_q;
    start        = 1'b0;
    fin          = 1'b0;
    none         = (jack_q == KIND_NONE);
    plugged      = (item_i.detect_pin == cfg_i.plugged_level);

    if ((item_i.detect_pin != prev_detect_q) && (none == plugged)) begin
      plug_armed_d = 1'b1;
      plug_cnt_d   = plug_load;
    end else if (plug_armed_q) begin
      plug_cnt_d = plug_cnt_q - 1'b1;
      if (plug_cnt_d == '0) begin
        plug_armed_d = 1'b0;
        if (!plugged) begin
          if (!none) begin
            // removal
            jack_d       = KIND_NONE;
            bias_d       = 1'b0;
            settling_d   = 1'b0;
            settle_cnt_d = '0;
          end
        end else if (none) begin
          // insertion, restarts a running settle
          bias_d       = 1'b1;
          start        = 1'b1;
          settle_cnt_d = settle_load;
          if (settle_load == '0) begin
            fin = 1'b1;
          end else begin
            settling_d = 1'b1;
          end
        end
      end
    end

    if (settling_d && !start) begin
      settle_cnt_d = settle_cnt_q - 1'b1;
      if (settle_cnt_d == '0) begin
        fin = 1'b1;
      end
    end

    if (fin) begin
      settling_d   = 1'b0;
      settle_cnt_d = '0;
      if (!plugged) begin
        bias_d = 1'b0;
      end else if (item_i.hook_pin == cfg_i.pressed_level) begin
        jack_d = KIND_NO_MIC;
        bias_d = 1'b0;
      end else begin
        jack_d = KIND_MIC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jack_q        <= KIND_NONE;
      plug_cnt_q    <= '0;
      plug_armed_q  <= 1'b0;
      settle_cnt_q  <= '0;
      settling_q    <= 1'b0;
      prev_detect_q <= PrevDetectRst;
      bias_q        <= 1'b0;
    end else if (step_i) begin
      jack_q        <= jack_d;
      plug_cnt_q    <= plug_cnt_d;
      plug_armed_q  <= plug_armed_d;
      settle_cnt_q  <= settle_cnt_d;
      settling_q    <= settling_d;
      prev_detect_q <= item_i.detect_pin;
      bias_q        <= bias_d;
    end
  end

  assign info_o.kind      = jack_d;
  assign info_o.bias      = bias_d;
  assign info_o.changed   = (jack_d != jack_q);
  assign info_o.mic_found = fin && plugged;

endmodule

`default_nettype wire

// File: design/hjd_button_ctrl.sv
// ----------------------------------------------------------------------------
// hjd_button_ctrl
// Hook button debounce and press/release reporting in microphone state.
// ----------------------------------------------------------------------------
`default_nettype none

module hjd_button_ctrl import hjd_pkg::*; #(
  parameter int unsigned TimerWidth = TimerWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  in_item_t   item_i,
  input  cfg_t       cfg_i,
  input  jack_info_t jack_i,
  output btn_info_t  btn_o
);

  localparam int unsigned LoadW = (TimerWidth > CfgTimeW) ? TimerWidth : CfgTimeW;
  localparam logic [LoadW-1:0] TimerMax = LoadW'({TimerWidth{1'b1}});

  logic [TimerWidth-1:0] btn_cnt_q, btn_cnt_d;
  logic                  btn_armed_q, btn_armed_d;
  logic                  prev_hook_q;
  logic                  held_q, held_d;
  btn_event_e            evt;

  logic [LoadW-1:0]      btn_ext;
  logic [TimerWidth-1:0] btn_load;
  logic                  prev_hook;

  always_comb begin
    btn_ext = LoadW'(cfg_i.button_debounce_ticks);
    if (btn_ext == '0) begin
      btn_ext = LoadW'(1);
    end
    if (btn_ext > TimerMax) begin
      btn_ext = TimerMax;
    end
    btn_load = btn_ext[TimerWidth-1:0];
  end

  always_comb begin
    btn_cnt_d   = btn_cnt_q;
    btn_armed_d = btn_armed_q;
    held_d      = held_q;
    evt         = BTN_NONE;
    // a fresh microphone test takes the current hook level as history
    prev_hook   = jack_i.mic_found ? item_i.hook_pin : prev_hook_q;
    if (jack_i.mic_found) begin
      btn_cnt_d   = '0;
      btn_armed_d = 1'b0;
    end

    if (jack_i.kind == KIND_MIC) begin
      if (item_i.hook_pin != prev_hook) begin
        btn_armed_d = 1'b1;
        btn_cnt_d   = btn_load;
      end else if (btn_armed_d) begin
        btn_cnt_d = btn_cnt_d - 1'b1;
        if (btn_cnt_d == '0) begin
          btn_armed_d = 1'b0;
          if (item_i.hook_pin == cfg_i.pressed_level) begin
            held_d = 1'b1;
            evt    = BTN_PRESS;
          end else begin
            held_d = 1'b0;
            evt    = BTN_RELEASE;
          end
        end
      end
    end else begin
      // held only survives in microphone state, removal clears it
      btn_armed_d = 1'b0;
      btn_cnt_d   = '0;
      held_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_cnt_q   <= '0;
      btn_armed_q <= 1'b0;
      prev_hook_q <= PrevHookRst;
      held_q      <= 1'b0;
    end else if (step_i) begin
      btn_cnt_q   <= btn_cnt_d;
      btn_armed_q <= btn_armed_d;
      prev_hook_q <= item_i.hook_pin;
      held_q      <= held_d;
    end
  end

  assign btn_o.evt  = evt;
  assign btn_o.down = held_d;

endmodule

`default_nettype wire

// File: design/headset_jack_detector_unit.sv
// ----------------------------------------------------------------------------
// headset_jack_detector_unit
// Headset jack detection with mic bias control and hook button reporting.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item is one tick with the sampled detect and hook pin levels;
//   each tick gives exactly one result item with the jack kind, bias enable,
//   a kind-changed flag, a button event and the current button state.
//   Channels: in (in_valid_i/in_ready_o/in_item_i), out (out_valid_o/
//   out_ready_i/out_item_o), and a config write channel (cfg_valid_i/
//   cfg_ready_o/cfg_index_i/cfg_data_i) that is always ready. Write config
//   only while no item is in flight.
//   Pipeline: an item is captured in the input register, evaluated
//   combinationally, and its result is loaded into the output register
//   once it is free or drains. Throughput is one item per cycle while
//   out_ready_i is high, set by the single evaluation stage between them.
//   Stall: while the output waits, the input register holds one more item;
//   in_ready_o drops only when both registers are full and out_ready_i low.
//   Reset: state goes to nothing plugged, bias off, button released, all
//   debounce timers idle; config returns to its reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module headset_jack_detector_unit import hjd_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = TimerWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic       s1_valid_q;
  in_item_t   s1_item_q;
  logic       out_valid_q;
  out_item_t  out_item_q;
  logic       step;
  cfg_t       cfg;
  jack_info_t jack_info;
  btn_info_t  btn_info;

  // the held item moves on whenever the output register is free or drains
  assign step       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || step;

  hjd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  hjd_jack_ctrl #(
    .TimerWidth (TIMER_WIDTH)
  ) u_jack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .info_o (jack_info)
  );

  hjd_button_ctrl #(
    .TimerWidth (TIMER_WIDTH)
  ) u_button (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .jack_i (jack_info),
    .btn_o  (btn_info)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
    if (step) begin
      out_item_q.jack_kind    <= jack_info.kind;
      out_item_q.bias_enable  <= jack_info.bias;
      out_item_q.jack_changed <= jack_info.changed;
      out_item_q.button_event <= btn_info.evt;
      out_item_q.button_down  <= btn_info.down;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// File: design/hjd_checker.sv
// ----------------------------------------------------------------------------
// hjd_checker
// Port-level checks on result items of the headset jack detector.
// ----------------------------------------------------------------------------
`default_nettype none

module hjd_checker import hjd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // with a headset without microphone the bias supply is off
  a_no_mic_bias: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.jack_kind == KIND_NO_MIC) |-> !out_item_o.bias_enable)
    else $error("bias on for headset without microphone");

  // button activity is only seen with a microphone headset
  a_button_mic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.button_down || (out_item_o.button_event != BTN_NONE))
    |-> (out_item_o.jack_kind == KIND_MIC) && out_item_o.bias_enable)
    else $error("button activity outside microphone state");

  // a reported event matches the button state shown with it
  a_event_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.button_event != BTN_NONE)
    |-> out_item_o.button_down == (out_item_o.button_event == BTN_PRESS))
    else $error("button event disagrees with button state");

endmodule

bind headset_jack_detector_unit hjd_checker u_hjd_checker (.*);

`default_nettype wire
